@@ sv/assert_macros.svh @@
// Assertion macros shared by the graph search block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define GCBP_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define GCBP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ sv/gcbp_pkg.sv @@
// Types and constants shared by the graph search block.
package gcbp_pkg;

   localparam int VERTEX_W = 4;
   localparam int COUNT_W  = 5;
   localparam int VALUE_W  = 5;
   localparam int MAX_VERTICES = 16;

   localparam logic [1:0] REQ_ADD_EDGE = 2'd0;
   localparam logic [1:0] REQ_ASSIGN   = 2'd1;
   localparam logic [1:0] REQ_PATH     = 2'd2;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_RANGE   = 2'd1;
   localparam logic [1:0] STATUS_NO_PATH = 2'd2;

   localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd16;

   typedef struct packed {
      logic [1:0]          req_type;
      logic [VERTEX_W-1:0] src_vertex;
      logic [VERTEX_W-1:0] dst_vertex;
   } gcbp_req_type;

   typedef struct packed {
      logic [1:0]          status;
      logic [VERTEX_W-1:0] vertex;
      logic [VALUE_W-1:0]  value;
      logic                last;
   } gcbp_rsp_type;

   typedef struct packed {
      logic         load;
      gcbp_rsp_type data;
   } gcbp_out_load_type;

   typedef struct packed {
      logic                en;
      logic [VERTEX_W-1:0] row;
      logic [VERTEX_W-1:0] col;
   } gcbp_edge_wr_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_EMIT1,
      S_A_SCAN,
      S_A_POP,
      S_A_EDGE,
      S_A_OUT,
      S_P_POP,
      S_P_EDGE,
      S_P_BACK,
      S_P_OUT
   } gcbp_state_type;

endpackage

@@ sv/gcbp_adj.sv @@
// Adjacency bitmap store with one edge write port and one row read port.
module gcbp_adj import gcbp_pkg::*; #(
   parameter int NODES = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  gcbp_edge_wr_type    edge_wr,
   input  logic [VERTEX_W-1:0] rd_row,
   output logic [((NODES < 16) ? NODES : 16)-1:0] row_bits
);
   localparam int VMAX = (NODES < 16) ? NODES : 16;
   localparam int IW   = $clog2(VMAX);

   logic [VMAX-1:0] adj_ff [VMAX];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < VMAX; i++) begin
            adj_ff[i] <= '0;
         end
      end else if (edge_wr.en) begin
         adj_ff[edge_wr.row[IW-1:0]][edge_wr.col[IW-1:0]] <= 1'b1;
      end
   end

   assign row_bits = adj_ff[rd_row[IW-1:0]];
endmodule

@@ sv/gcbp_out.sv @@
// Result output register that frees its slot when the receiver takes the result.
module gcbp_out import gcbp_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  gcbp_out_load_type out_load,
   output logic              slot_free,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output gcbp_rsp_type      rsp_data
);
   logic         valid_ff, valid_in;
   gcbp_rsp_type data_ff;

   assign slot_free = !valid_ff || !rsp_stall;
   assign valid_in  = out_load.load || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load.load) begin
         data_ff <= out_load.data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;
endmodule

@@ sv/gcbp_core.sv @@
// Sequencer that runs breadth-first searches one adjacency bit per cycle.
`include "assert_macros.svh"
module gcbp_core import gcbp_pkg::*; #(
   parameter int NODES = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  gcbp_req_type        req_data,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [COUNT_W-1:0]  csr_data,
   output gcbp_edge_wr_type    edge_wr,
   output logic [VERTEX_W-1:0] rd_row,
   input  logic [((NODES < 16) ? NODES : 16)-1:0] row_bits,
   input  logic                slot_free,
   output gcbp_out_load_type   out_load
);
   localparam int VMAX = (NODES < 16) ? NODES : 16;
   localparam int IW   = $clog2(VMAX);
   localparam logic [COUNT_W-1:0] VMAX_C = COUNT_W'(VMAX);

   gcbp_state_type state_ff, state_in;
   gcbp_req_type   req_ff;
   logic [COUNT_W-1:0] vc_ff, vc_in;
   logic [COUNT_W-1:0] n_live;
   logic [COUNT_W-1:0] sc_ff, sc_in;
   logic [COUNT_W-1:0] v_ff, v_in;
   logic [COUNT_W-1:0] head_ff, head_in;
   logic [COUNT_W-1:0] tail_ff, tail_in;
   logic [VALUE_W-1:0] dist_ff, dist_in;
   logic [IW-1:0]      u_ff, u_in;
   logic [IW-1:0]      cur_ff, cur_in;
   logic [VERTEX_W-1:0] len_ff, len_in;
   gcbp_rsp_type       one_ff, one_in;

   logic [VALUE_W-1:0]  comp_ff [VMAX];
   logic [IW-1:0]       pred_ff [VMAX];
   logic [VERTEX_W-1:0] hops_ff [VMAX];
   logic [IW-1:0]       queue_ff [VMAX];
   logic [IW-1:0]       path_ff [VMAX];
   logic [VMAX-1:0]     seen_ff;

   logic                accept, s_bad, d_bad, edge_hit;
   logic [IW-1:0]       s_idx, d_idx, v_idx, sc_idx, comp_addr;
   logic [VALUE_W-1:0]  comp_rd;
   logic                comp_we, pred_we, hops_we, queue_we, path_we, seen_clr, seen_we;
   logic [IW-1:0]       comp_wa, pw_a, queue_wa, seen_wa;
   logic [VALUE_W-1:0]  comp_wd;
   logic [IW-1:0]       pred_wd, queue_wd;
   logic [VERTEX_W-1:0] hops_wd;

   assign n_live = (vc_ff == '0) ? COUNT_W'(1) : ((vc_ff > VMAX_C) ? VMAX_C : vc_ff);
   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = (state_ff == S_IDLE);
   assign s_bad  = {1'b0, req_ff.src_vertex} >= n_live;
   assign d_bad  = {1'b0, req_ff.dst_vertex} >= n_live;
   assign s_idx  = req_ff.src_vertex[IW-1:0];
   assign d_idx  = req_ff.dst_vertex[IW-1:0];
   assign v_idx  = v_ff[IW-1:0];
   assign sc_idx = sc_ff[IW-1:0];
   assign comp_addr = (state_ff == S_A_EDGE) ? v_idx : sc_idx;
   assign comp_rd   = comp_ff[comp_addr];
   assign rd_row    = VERTEX_W'(u_ff);
   assign edge_hit  = row_bits[v_idx];
   assign vc_in     = (csr_valid && csr_ready) ? csr_data : vc_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) state_in = S_DISPATCH;
         end
         S_DISPATCH: begin
            case (req_ff.req_type)
               REQ_ADD_EDGE: state_in = S_EMIT1;
               REQ_ASSIGN:   state_in = S_A_SCAN;
               REQ_PATH: begin
                  if (s_bad || d_bad || req_ff.src_vertex == req_ff.dst_vertex) begin
                     state_in = S_EMIT1;
                  end else begin
                     state_in = S_P_POP;
                  end
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_EMIT1: begin
            if (slot_free) state_in = S_IDLE;
         end
         S_A_SCAN: begin
            if (sc_ff == n_live) begin
               state_in = S_A_OUT;
            end else if (comp_rd == '0) begin
               state_in = S_A_POP;
            end
         end
         S_A_POP: begin
            state_in = (head_ff == tail_ff) ? S_A_SCAN : S_A_EDGE;
         end
         S_A_EDGE: begin
            if (v_ff == n_live) state_in = S_A_POP;
         end
         S_A_OUT: begin
            if (slot_free && sc_ff + 1'b1 == n_live) state_in = S_IDLE;
         end
         S_P_POP: begin
            state_in = (head_ff == tail_ff) ? S_EMIT1 : S_P_EDGE;
         end
         S_P_EDGE: begin
            if (v_ff == n_live) begin
               state_in = S_P_POP;
            end else if (edge_hit && !seen_ff[v_idx] && v_idx == d_idx) begin
               state_in = S_P_BACK;
            end
         end
         S_P_BACK: begin
            if (sc_ff == '0) state_in = S_P_OUT;
         end
         S_P_OUT: begin
            if (slot_free && sc_ff == {1'b0, len_ff}) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      sc_in = sc_ff; v_in = v_ff; head_in = head_ff; tail_in = tail_ff;
      dist_in = dist_ff; u_in = u_ff; cur_in = cur_ff; len_in = len_ff; one_in = one_ff;
      comp_we = 1'b0; comp_wa = sc_idx; comp_wd = dist_ff;
      pred_we = 1'b0; hops_we = 1'b0; pw_a = v_idx; pred_wd = u_ff;
      hops_wd = hops_ff[u_ff] + 1'b1;
      queue_we = 1'b0; queue_wa = tail_ff[IW-1:0]; queue_wd = v_idx;
      path_we = 1'b0; seen_clr = 1'b0; seen_we = 1'b0; seen_wa = v_idx;
      edge_wr = '0;
      out_load = '0;
      case (state_ff)
         S_DISPATCH: begin
            one_in.status = STATUS_OK;
            one_in.vertex = req_ff.src_vertex;
            one_in.value  = '0;
            one_in.last   = 1'b1;
            case (req_ff.req_type)
               REQ_ADD_EDGE: begin
                  if (s_bad || d_bad) begin
                     one_in.status = STATUS_RANGE;
                  end else begin
                     edge_wr.en  = 1'b1;
                     edge_wr.row = req_ff.src_vertex;
                     edge_wr.col = req_ff.dst_vertex;
                  end
               end
               REQ_ASSIGN: begin
                  sc_in   = '0;
                  dist_in = VALUE_W'(1);
               end
               REQ_PATH: begin
                  if (s_bad || d_bad) begin
                     one_in.status = STATUS_RANGE;
                  end else if (req_ff.src_vertex != req_ff.dst_vertex) begin
                     seen_clr = 1'b1; seen_we = 1'b1; seen_wa = s_idx;
                     pred_we = 1'b1; hops_we = 1'b1; pw_a = s_idx;
                     pred_wd = s_idx; hops_wd = '0;
                     queue_we = 1'b1; queue_wa = '0; queue_wd = s_idx;
                     head_in = '0; tail_in = COUNT_W'(1);
                  end
               end
               default: ;
            endcase
         end
         S_EMIT1: begin
            out_load.load = slot_free;
            out_load.data = one_ff;
         end
         S_A_SCAN: begin
            if (sc_ff == n_live) begin
               sc_in = '0;
            end else if (comp_rd == '0) begin
               comp_we = 1'b1; comp_wa = sc_idx; comp_wd = dist_ff;
               queue_we = 1'b1; queue_wa = '0; queue_wd = sc_idx;
               head_in = '0; tail_in = COUNT_W'(1);
            end else begin
               sc_in = sc_ff + 1'b1;
            end
         end
         S_A_POP, S_P_POP: begin
            if (head_ff == tail_ff) begin
               if (state_ff == S_A_POP) begin
                  dist_in = dist_ff + 1'b1;
                  sc_in   = sc_ff + 1'b1;
               end else begin
                  one_in.status = STATUS_NO_PATH;
                  one_in.vertex = req_ff.dst_vertex;
                  one_in.value  = '0;
                  one_in.last   = 1'b1;
               end
            end else begin
               u_in    = queue_ff[head_ff[IW-1:0]];
               head_in = head_ff + 1'b1;
               v_in    = '0;
            end
         end
         S_A_EDGE: begin
            if (v_ff != n_live) begin
               if (edge_hit && comp_rd == '0) begin
                  comp_we = 1'b1; comp_wa = v_idx; comp_wd = dist_ff;
                  queue_we = 1'b1;
                  tail_in = tail_ff + 1'b1;
               end
               v_in = v_ff + 1'b1;
            end
         end
         S_A_OUT: begin
            out_load.load        = slot_free;
            out_load.data.status = STATUS_OK;
            out_load.data.vertex = VERTEX_W'(sc_idx);
            out_load.data.value  = comp_rd;
            out_load.data.last   = (sc_ff + 1'b1 == n_live);
            if (slot_free) sc_in = sc_ff + 1'b1;
         end
         S_P_EDGE: begin
            if (v_ff != n_live) begin
               if (edge_hit && !seen_ff[v_idx]) begin
                  seen_we = 1'b1;
                  pred_we = 1'b1; hops_we = 1'b1;
                  queue_we = 1'b1;
                  tail_in = tail_ff + 1'b1;
                  if (v_idx == d_idx) begin
                     len_in = hops_wd;
                     sc_in  = {1'b0, hops_wd};
                     cur_in = d_idx;
                  end
               end
               v_in = v_ff + 1'b1;
            end
         end
         S_P_BACK: begin
            path_we = 1'b1;
            cur_in  = pred_ff[cur_ff];
            if (sc_ff != '0) sc_in = sc_ff - 1'b1;
         end
         S_P_OUT: begin
            out_load.load        = slot_free;
            out_load.data.status = STATUS_OK;
            out_load.data.vertex = VERTEX_W'(path_ff[sc_idx]);
            out_load.data.value  = sc_ff;
            out_load.data.last   = (sc_ff == {1'b0, len_ff});
            if (slot_free) sc_in = sc_ff + 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         vc_ff    <= COUNT_RESET;
         head_ff  <= '0;
         tail_ff  <= '0;
         seen_ff  <= '0;
         for (int i = 0; i < VMAX; i++) begin
            comp_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         vc_ff    <= vc_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         if (comp_we) comp_ff[comp_wa] <= comp_wd;
         if (seen_clr) begin
            seen_ff <= VMAX'(1) << seen_wa;
         end else if (seen_we) begin
            seen_ff[seen_wa] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) req_ff <= req_data;
      sc_ff   <= sc_in;
      v_ff    <= v_in;
      dist_ff <= dist_in;
      u_ff    <= u_in;
      cur_ff  <= cur_in;
      len_ff  <= len_in;
      one_ff  <= one_in;
      if (pred_we) pred_ff[pw_a] <= pred_wd;
      if (hops_we) hops_ff[pw_a] <= hops_wd;
      if (queue_we) queue_ff[queue_wa] <= queue_wd;
      if (path_we) path_ff[sc_idx] <= cur_ff;
   end

   `GCBP_ASSERT_IMP(a_tail_bound, clock, reset, state_ff != S_IDLE, tail_ff <= VMAX_C)
   `GCBP_ASSERT_IMP(a_head_le_tail, clock, reset, state_ff != S_IDLE, head_ff <= tail_ff)
   `GCBP_ASSERT_IMP(a_load_state, clock, reset, out_load.load, state_ff == S_EMIT1 || state_ff == S_A_OUT || state_ff == S_P_OUT)
   `GCBP_ASSERT_NEXT(a_accept_dispatch, clock, reset, accept, state_ff == S_DISPATCH)
endmodule

@@ sv/graph_component_and_bfs_path.sv @@
// Top level of the graph search block: adjacency store, sequencer and output register.
//
// The request channel carries one request per handshake: add an edge, label
// components, or find a shortest path. req_stall is high from acceptance until
// the sequencer has handed the last result to the output register.
// The rsp channel delivers one result per cycle at most, with last set on the
// final result of each request. A held rsp_stall freezes the output register
// and the sequencer waits for the slot.
// The csr channel writes the vertex count; it is ready only while idle.
// An add-edge request passes through the dispatch and emit states to its result.
// A search checks one adjacency bit per cycle in the single edge-test step of
// the sequencer, for each vertex that it takes from the queue.
// Reset clears the graph and all labels, empties the output register, and sets the
// vertex count to 16.
module graph_component_and_bfs_path import gcbp_pkg::*; #(
   parameter int NODES = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  gcbp_req_type       req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output gcbp_rsp_type       rsp_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [COUNT_W-1:0] csr_data
);
   localparam int VMAX = (NODES < 16) ? NODES : 16;

   gcbp_edge_wr_type    edge_wr;
   logic [VERTEX_W-1:0] rd_row;
   logic [VMAX-1:0]     row_bits;
   logic                slot_free;
   gcbp_out_load_type   out_load;

   gcbp_adj #(.NODES(NODES)) u_adj (
      .clock    (clock),
      .reset    (reset),
      .edge_wr  (edge_wr),
      .rd_row   (rd_row),
      .row_bits (row_bits)
   );

   gcbp_core #(.NODES(NODES)) u_core (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .edge_wr   (edge_wr),
      .rd_row    (rd_row),
      .row_bits  (row_bits),
      .slot_free (slot_free),
      .out_load  (out_load)
   );

   gcbp_out u_out (
      .clock     (clock),
      .reset     (reset),
      .out_load  (out_load),
      .slot_free (slot_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );
endmodule
